// ===== rtl/core/tbgfc_pkg.sv =====
// Package for the two-border grid flow count core: sizes, register indexes and shared types.
// No dependencies; every other file of the core imports it.
`default_nettype none
package tbgfc_pkg;
   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_MAX_COLS    = 64;
   localparam int DEF_HEIGHT_BITS = 16;
   localparam int IN_HEIGHT_W     = 16;
   localparam int DIM_W           = 7;
   localparam int COUNT_W         = 13;
   localparam int CSR_DATA_W      = 7;
   localparam int CSR_ADDR_W      = 1;

   localparam logic [CSR_ADDR_W-1:0] REG_GRID_ROWS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_GRID_COLS = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/core/tbgfc_if.sv =====
// Valid/ready channel interfaces for the two-border grid flow count core.
// Depends on tbgfc_pkg for the payload widths.
`default_nettype none
interface tbgfc_req_if import tbgfc_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [IN_HEIGHT_W-1:0] height;
   logic                          last_cell;
   modport source (output valid, height, last_cell, input ready);
   modport sink   (input valid, height, last_cell, output ready);
endinterface

interface tbgfc_rsp_if import tbgfc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] both_reach_count;
   modport source (output valid, both_reach_count, input ready);
   modport sink   (input valid, both_reach_count, output ready);
endinterface

interface tbgfc_csr_if import tbgfc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/two_border_grid_flow_count_core.sv =====
// Two-border grid flow count core. Load: one cell per cycle, ready held high while loading.
// After the last cell: a clearing pass over the N = rows*cols reached-map entries; per fill a read and
// a mark-and-push per border seed, then per visited cell a pop, stack and height reads and a check of
// each neighbor; an empty stack ends it. A counting sweep follows; the result waits in an output register.
// Reset is synchronous, active high: registers return to 64 rows by 64 cols, load position 0.
// The height memory is not cleared; cells must be written before they are read.
`default_nettype none
module two_border_grid_flow_count_core
   import tbgfc_pkg::*;
#(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tbgfc_req_if.sink   req,
   tbgfc_rsp_if.source rsp,
   tbgfc_csr_if.sink   csr
);
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int SW    = RW + CW;

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_SEED  = 4'd2;
   localparam logic [3:0] S_POP   = 4'd3;
   localparam logic [3:0] S_CUR   = 4'd4;
   localparam logic [3:0] S_NRD   = 4'd5;
   localparam logic [3:0] S_NCHK  = 4'd6;
   localparam logic [3:0] S_CNT   = 4'd7;
   localparam logic [3:0] S_CNTW  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0]   state_ff, state_in;
   logic [DIM_W-1:0] rows_reg_ff, cols_reg_ff;
   logic [PW-1:0] load_pos_ff, load_pos_in;
   logic [RW-1:0] rows_ff, rows_in;
   logic [CW-1:0] cols_ff, cols_in;
   logic [PW-1:0] ncells_ff, ncells_in;

   // Memories: heights, reached maps (two bits per entry), walk stack of row/column pairs.
   logic signed [HEIGHT_BITS-1:0] hmem [CELLS];
   logic [1:0]                    mmem [CELLS];
   logic [SW-1:0]                 smem [CELLS];

   logic                          h_we, m_we, s_we;
   logic [AW-1:0]                 h_addr, m_addr, m_waddr, s_addr;
   logic signed [HEIGHT_BITS-1:0] h_wdata, h_rdata_ff;
   logic [1:0]                    m_wdata, m_rdata_ff;
   logic [SW-1:0]                 s_wdata, s_rdata_ff;

   // Fill control.
   logic          pass_ff, pass_in;          // 0: first fill, 1: second fill
   logic [PW-1:0] sp_ff, sp_in;
   logic [PW-1:0] seed_ff, seed_in;          // sweep index for seeding, clearing, counting
   logic [AW-1:0] cur_ff, cur_in;
   logic [RW-1:0] cur_r_ff, cur_r_in;
   logic [CW-1:0] cur_c_ff, cur_c_in;
   logic signed [HEIGHT_BITS-1:0] cur_h_ff, cur_h_in;
   logic [1:0]    dir_ff, dir_in;
   logic [AW-1:0] nb_ff, nb_in;
   logic          nb_ok_ff, nb_ok_in;
   logic [RW-1:0] sr_ff, sr_in;              // seed row/col walker
   logic [CW-1:0] sc_ff, sc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic          cnt_v_ff, cnt_v_in;

   logic [RW-1:0] rows_use;
   logic [CW-1:0] cols_use;
   logic [PW-1:0] n_use;
   logic          req_fire;

   // Register writes.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_reg_ff <= DIM_W'(64);
         cols_reg_ff <= DIM_W'(64);
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_GRID_ROWS: rows_reg_ff <= csr.data;
            REG_GRID_COLS: cols_reg_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // Clamp register values into the range the memory holds.
   always_comb begin
      if (rows_reg_ff == '0) rows_use = RW'(1);
      else if (32'(rows_reg_ff) > MAX_ROWS) rows_use = RW'(MAX_ROWS);
      else rows_use = RW'(rows_reg_ff);
      if (cols_reg_ff == '0) cols_use = CW'(1);
      else if (32'(cols_reg_ff) > MAX_COLS) cols_use = CW'(MAX_COLS);
      else cols_use = CW'(cols_reg_ff);
   end
   assign n_use = PW'(rows_use) * PW'(cols_use);

   assign req.ready = (state_ff == S_LOAD);
   assign req_fire  = req.valid && req.ready;
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.both_reach_count = count_ff;

   // Memory ports.
   always_ff @(posedge clock) begin
      if (h_we) hmem[h_addr] <= h_wdata;
      h_rdata_ff <= hmem[h_addr];
   end
   always_ff @(posedge clock) begin
      if (m_we) mmem[m_waddr] <= m_wdata;
      m_rdata_ff <= mmem[m_addr];
   end
   always_ff @(posedge clock) begin
      if (s_we) smem[s_addr] <= s_wdata;
      s_rdata_ff <= smem[s_addr];
   end

   // Neighbor candidate for the current direction: left, right, up, down.
   logic          nb_valid;
   logic [AW-1:0] nb_idx;
   logic [RW-1:0] nb_r;
   logic [CW-1:0] nb_c;
   always_comb begin
      nb_valid = 1'b0;
      nb_idx   = cur_ff;
      nb_r     = cur_r_ff;
      nb_c     = cur_c_ff;
      case (dir_ff)
         2'd0: begin
            nb_valid = (cur_c_ff != '0); nb_c = cur_c_ff - CW'(1); nb_idx = cur_ff - AW'(1);
         end
         2'd1: begin
            nb_valid = (32'(cur_c_ff) + 1 < 32'(cols_ff));
            nb_c = cur_c_ff + CW'(1); nb_idx = cur_ff + AW'(1);
         end
         2'd2: begin
            nb_valid = (cur_r_ff != '0);
            nb_r = cur_r_ff - RW'(1); nb_idx = cur_ff - AW'(cols_ff);
         end
         default: begin
            nb_valid = (32'(cur_r_ff) + 1 < 32'(rows_ff));
            nb_r = cur_r_ff + RW'(1); nb_idx = cur_ff + AW'(cols_ff);
         end
      endcase
   end

   // Seed cell for the current sweep step: pass 0 walks left column then top row,
   // pass 1 walks right column then bottom row.
   logic [AW-1:0] seed_idx;
   logic          seed_colphase;
   logic [RW-1:0] sr_next;
   logic [CW-1:0] sc_next;
   logic [RW-1:0] seed_r;
   logic [CW-1:0] seed_c;
   assign seed_colphase = (32'(seed_ff) < 32'(rows_ff));
   always_comb begin
      if (seed_colphase) begin
         seed_r = sr_ff;
         seed_c = pass_ff ? cols_ff - CW'(1) : '0;
      end else begin
         seed_r = pass_ff ? rows_ff - RW'(1) : '0;
         seed_c = sc_ff;
      end
      seed_idx = AW'(AW'(seed_r) * AW'(cols_ff)) + AW'(seed_c);
   end

   logic map_bit;
   assign map_bit = pass_ff ? m_rdata_ff[1] : m_rdata_ff[0];

   always_comb begin
      state_in    = state_ff;
      load_pos_in = load_pos_ff;
      rows_in = rows_ff; cols_in = cols_ff; ncells_in = ncells_ff;
      pass_in = pass_ff; sp_in = sp_ff; seed_in = seed_ff;
      cur_in = cur_ff; cur_r_in = cur_r_ff; cur_c_in = cur_c_ff; cur_h_in = cur_h_ff;
      dir_in = dir_ff; nb_in = nb_ff; nb_ok_in = nb_ok_ff;
      sr_in = sr_ff; sc_in = sc_ff; count_in = count_ff; cnt_v_in = 1'b0;
      h_we = 1'b0; h_addr = cur_ff; h_wdata = HEIGHT_BITS'($unsigned(req.height));
      m_we = 1'b0; m_addr = cur_ff; m_waddr = cur_ff; m_wdata = m_rdata_ff;
      s_we = 1'b0; s_addr = AW'(sp_ff); s_wdata = {seed_r, seed_c};
      sr_next = sr_ff; sc_next = sc_ff;
      unique case (state_ff)
         S_LOAD: begin
            h_addr = AW'(load_pos_ff);
            if (req_fire) begin
               if (load_pos_ff < n_use) begin
                  h_we = 1'b1;
                  load_pos_in = load_pos_ff + PW'(1);
               end else begin
                  load_pos_in = n_use;
               end
               if (req.last_cell) begin
                  load_pos_in = '0;
                  rows_in = rows_use; cols_in = cols_use; ncells_in = n_use;
                  seed_in = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            m_we = 1'b1; m_waddr = AW'(seed_ff); m_wdata = 2'b00;
            if (seed_ff == ncells_ff - PW'(1)) begin
               seed_in = '0; sp_in = '0; pass_in = 1'b0;
               sr_in = '0; sc_in = '0;
               m_addr = '0;
               state_in = S_SEED;
            end else begin
               seed_in = seed_ff + PW'(1);
            end
         end
         S_SEED: begin
            // Each seed step reads the map at the seed index, then marks and pushes the seed if unmarked.
            m_addr = seed_idx;
            if (!nb_ok_ff) begin
               nb_ok_in = 1'b1;
            end else begin
               nb_ok_in = 1'b0;
               if (!map_bit) begin
                  m_we = 1'b1; m_waddr = seed_idx;
                  m_wdata = pass_ff ? {1'b1, m_rdata_ff[0]} : {m_rdata_ff[1], 1'b1};
                  s_we = 1'b1; s_addr = AW'(sp_ff); s_wdata = {seed_r, seed_c};
                  sp_in = sp_ff + PW'(1);
               end
               if (seed_colphase) sr_next = sr_ff + RW'(1);
               else sc_next = sc_ff + CW'(1);
               sr_in = sr_next; sc_in = sc_next;
               if (32'(seed_ff) + 1 == 32'(rows_ff) + 32'(cols_ff)) begin
                  state_in = S_POP;
               end
               seed_in = seed_ff + PW'(1);
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               if (!pass_ff) begin
                  pass_in = 1'b1; seed_in = '0; sr_in = '0; sc_in = '0;
                  state_in = S_SEED;
               end else begin
                  seed_in = '0; count_in = '0;
                  state_in = S_CNT;
               end
            end else begin
               sp_in = sp_ff - PW'(1);
               s_addr = AW'(sp_ff - PW'(1));
               state_in = S_CUR;
               nb_ok_in = 1'b0;
            end
         end
         S_CUR: begin
            // Stack data valid: rebuild the cell index and read its height.
            if (!nb_ok_ff) begin
               cur_r_in = s_rdata_ff[SW-1:CW];
               cur_c_in = s_rdata_ff[CW-1:0];
               cur_in = AW'(AW'(cur_r_in) * AW'(cols_ff)) + AW'(cur_c_in);
               h_addr = cur_in;
               nb_ok_in = 1'b1;
            end else begin
               cur_h_in = h_rdata_ff;
               dir_in = 2'd0;
               nb_ok_in = 1'b0;
               state_in = S_NRD;
            end
         end
         S_NRD: begin
            nb_in = nb_idx; nb_ok_in = nb_valid;
            h_addr = nb_idx; m_addr = nb_idx;
            state_in = S_NCHK;
         end
         S_NCHK: begin
            if (nb_ok_ff && !map_bit && (h_rdata_ff >= cur_h_ff)) begin
               m_we = 1'b1; m_waddr = nb_ff;
               m_wdata = pass_ff ? {1'b1, m_rdata_ff[0]} : {m_rdata_ff[1], 1'b1};
               s_we = 1'b1; s_addr = AW'(sp_ff); s_wdata = {nb_r, nb_c};
               sp_in = sp_ff + PW'(1);
            end
            nb_ok_in = 1'b0;
            if (dir_ff == 2'd3) state_in = S_POP;
            else begin
               dir_in = dir_ff + 2'd1;
               state_in = S_NRD;
            end
         end
         S_CNT: begin
            m_addr = AW'(seed_ff);
            cnt_v_in = 1'b1;
            if (cnt_v_ff && m_rdata_ff == 2'b11) count_in = count_ff + COUNT_W'(1);
            if (seed_ff == ncells_ff - PW'(1)) state_in = S_CNTW;
            else seed_in = seed_ff + PW'(1);
         end
         S_CNTW: begin
            if (m_rdata_ff == 2'b11) count_in = count_ff + COUNT_W'(1);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; load_pos_ff <= '0; sp_ff <= '0; nb_ok_ff <= 1'b0;
         cnt_v_ff <= 1'b0; pass_ff <= 1'b0;
      end else begin
         state_ff <= state_in; load_pos_ff <= load_pos_in; sp_ff <= sp_in;
         nb_ok_ff <= nb_ok_in; cnt_v_ff <= cnt_v_in; pass_ff <= pass_in;
      end
   end
   always_ff @(posedge clock) begin
      rows_ff <= rows_in; cols_ff <= cols_in; ncells_ff <= ncells_in;
      seed_ff <= seed_in; cur_ff <= cur_in; cur_r_ff <= cur_r_in; cur_c_ff <= cur_c_in;
      cur_h_ff <= cur_h_in; dir_ff <= dir_in; nb_ff <= nb_in;
      sr_ff <= sr_in; sc_ff <= sc_in; count_ff <= count_in;
   end

   // Checks on the sequencer.
   a_ready_only_load: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_LOAD) else $error("ready outside load");
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) <= CELLS) else $error("stack overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(count_ff)) else $error("result lost");
endmodule
`default_nettype wire
